>>> design/pdr_pkg.sv
`timescale 1ns / 1ps
package pdr_pkg;

	localparam int MAX_WIDTH = 512;
	localparam int MAX_HEIGHT = 256;
	localparam int TRIG_BITS = 16;
	localparam int QUARTER = 1 << (TRIG_BITS - 2);

	// phase dividers: divisor width and quotient bits
	localparam int PH_DW = 9;
	localparam int PH_QW = TRIG_BITS + 1;
	// depth divider
	localparam int DP_DW = 33;
	localparam int DP_QW = 32;
	// quarter-sine pipeline latency
	localparam int LSIN = 22;

	localparam int QDEPTH = 4;

	localparam logic [30:0] Q30_ONE = 31'h4000_0000;
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

	localparam logic [7:0] HORNER_DIV [6] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	localparam logic [1:0] REG_WIDTH = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;

	typedef struct packed {
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic signed [31:0] plane_dist;
	} plane_t;

	typedef struct packed {
		logic [8:0]  out_col;
		logic [7:0]  out_row;
		logic        no_plane;
		logic [8:0]  wm1;
		logic [7:0]  hm1;
		logic [24:0] pt_num;
		logic [22:0] pp_num;
	} coord_t;

	typedef struct packed {
		coord_t coord;
		plane_t plane;
	} item_t;

endpackage

>>> design/pdr_div.sv
`timescale 1ns / 1ps
module pdr_div #(
	parameter int DW = 9,
	parameter int QW = 17
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] num_hi,
	input  logic [QW-1:0] num_lo,
	input  logic [DW-1:0] divisor,
	output logic [QW-1:0] quo
);
	logic [DW-1:0] rem_q [QW];
	logic [QW-1:0] lo_q [QW];
	logic [QW-1:0] quo_q [QW];
	logic [DW-1:0] div_q [QW];

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [DW-1:0] rem_in;
		logic [DW-1:0] div_in;
		logic [QW-1:0] lo_in;
		logic [QW-1:0] quo_in;
		logic [DW:0]   trial;
		logic          take;

		if (k == 0) begin : g_first
			assign rem_in = num_hi;
			assign div_in = divisor;
			assign lo_in = num_lo;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_q[k-1];
			assign div_in = div_q[k-1];
			assign lo_in = lo_q[k-1];
			assign quo_in = quo_q[k-1];
		end

		// bring down one numerator bit and try the subtract
		assign trial = {rem_in, lo_in[QW-1]};
		assign take = trial >= {1'b0, div_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= take ? DW'(trial - {1'b0, div_in}) : DW'(trial);
				lo_q[k] <= {lo_in[QW-2:0], 1'b0};
				quo_q[k] <= {quo_in[QW-2:0], take};
				div_q[k] <= div_in;
			end
		end
	end

	assign quo = quo_q[QW-1];

endmodule

>>> design/pdr_sine.sv
`timescale 1ns / 1ps
module pdr_sine (
	input  logic        clk,
	input  logic        en,
	input  logic [14:0] r,
	output logic [30:0] s
);
	import pdr_pkg::*;

	localparam int STEPS = 6;

	logic [30:0] x_s1;
	logic [30:0] x_s2;
	logic [31:0] x2_s2;
	logic [31:0] n_q [STEPS];
	logic [31:0] q0_q [STEPS];
	logic [31:0] nb_q [STEPS];
	logic [30:0] t_q [STEPS];
	logic [31:0] x2a_q [STEPS];
	logic [31:0] x2b_q [STEPS];
	logic [31:0] x2c_q [STEPS];
	logic [30:0] xa_q [STEPS];
	logic [30:0] xb_q [STEPS];
	logic [30:0] xc_q [STEPS];
	logic [30:0] sm_q;
	logic [30:0] s_q;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= 31'((46'(r) * 46'(HALF_PI_Q30)) >> (TRIG_BITS - 2));
			x2_s2 <= 32'((62'(x_s1) * 62'(x_s1)) >> 30);
			x_s2 <= x_s1;
		end
	end

	// one Horner term per step: multiply, reciprocal multiply, correct
	for (genvar i = 0; i < STEPS; i++) begin : g_horner
		localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(HORNER_DIV[i]));
		logic [30:0] t_in;
		logic [31:0] x2_in;
		logic [30:0] x_in;
		logic [31:0] rem;
		logic [31:0] qc;

		if (i == 0) begin : g_first
			assign t_in = Q30_ONE;
			assign x2_in = x2_s2;
			assign x_in = x_s2;
		end else begin : g_next
			assign t_in = t_q[i-1];
			assign x2_in = x2c_q[i-1];
			assign x_in = xc_q[i-1];
		end

		assign rem = nb_q[i] - 32'(40'(q0_q[i]) * 40'(HORNER_DIV[i]));
		assign qc = (rem >= 32'(HORNER_DIV[i])) ? q0_q[i] + 32'd1 : q0_q[i];

		always_ff @(posedge clk) begin
			if (en) begin
				n_q[i] <= 32'((63'(x2_in) * 63'(t_in)) >> 30);
				x2a_q[i] <= x2_in;
				xa_q[i] <= x_in;
				q0_q[i] <= 32'((64'(n_q[i]) * 64'(RECIP)) >> 32);
				nb_q[i] <= n_q[i];
				x2b_q[i] <= x2a_q[i];
				xb_q[i] <= xa_q[i];
				t_q[i] <= Q30_ONE - 31'(qc);
				x2c_q[i] <= x2b_q[i];
				xc_q[i] <= xb_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sm_q <= 31'((62'(xc_q[STEPS-1]) * 62'(t_q[STEPS-1])) >> 30);
			s_q <= (sm_q > Q30_ONE) ? Q30_ONE : sm_q;
		end
	end

	assign s = s_q;

endmodule

>>> design/pdr_front.sv
`timescale 1ns / 1ps
module pdr_front #(
	parameter int MAX_PLANES = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 cmd,
	input  logic [8:0]           pixel_col,
	input  logic [7:0]           pixel_row,
	input  logic [7:0]           plane_index,
	input  logic signed [15:0]   normal_x,
	input  logic signed [15:0]   normal_y,
	input  logic signed [15:0]   normal_z,
	input  logic signed [31:0]   plane_dist,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [9:0]           cfg_data,
	output logic                 push,
	output pdr_pkg::item_t       push_item,
	input  logic                 q_full
);
	import pdr_pkg::*;

	localparam int AW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;

	logic [9:0]  width_q;
	logic [8:0]  height_q;
	logic [9:0]  w_eff;
	logic [8:0]  h_eff;
	logic [8:0]  wm1;
	logic [7:0]  hm1;
	logic [8:0]  col_c;
	logic [7:0]  row_c;
	logic [8:0]  col_m;
	logic [7:0]  row_m;
	logic        accept;
	logic        in_range;
	logic [AW-1:0] addr;
	coord_t      coord_in;
	coord_t      coord_s1;
	logic        in_range_s1;
	logic        s1_v_q;
	plane_t      rd_s1;
	plane_t      plane_mem [MAX_PLANES];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 10'(MAX_WIDTH);
			height_q <= 9'(MAX_HEIGHT);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WIDTH: width_q <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q < 10'd2) w_eff = 10'd2;
		else if (width_q > 10'(MAX_WIDTH)) w_eff = 10'(MAX_WIDTH);
		else w_eff = width_q;
		if (height_q < 9'd2) h_eff = 9'd2;
		else if (height_q > 9'(MAX_HEIGHT)) h_eff = 9'(MAX_HEIGHT);
		else h_eff = height_q;
	end

	assign wm1 = 9'(w_eff - 10'd1);
	assign hm1 = 8'(h_eff - 9'd1);
	assign col_c = (pixel_col > wm1) ? wm1 : pixel_col;
	assign row_c = (pixel_row > hm1) ? hm1 : pixel_row;
	assign col_m = wm1 - col_c;
	assign row_m = hm1 - row_c;

	always_comb begin
		coord_in.out_col = col_m;
		coord_in.out_row = row_c;
		coord_in.no_plane = (plane_index == 8'd0);
		coord_in.wm1 = wm1;
		coord_in.hm1 = hm1;
		// rounded numerators of the azimuth and elevation phases
		coord_in.pt_num = {col_m, {TRIG_BITS{1'b0}}} + 25'(wm1[8:1]);
		coord_in.pp_num = {row_m, {(TRIG_BITS - 1){1'b0}}} + 23'(hm1[7:1]);
	end

	assign in_range = {1'b0, plane_index} < 9'(MAX_PLANES);
	assign addr = plane_index[AW-1:0];
	assign in_ready = !s1_v_q || !q_full;
	assign accept = in_valid && in_ready;
	assign push = s1_v_q && !q_full;

	always_ff @(posedge clk) begin
		if (accept && cmd == CMD_LOAD && in_range) begin
			plane_mem[addr] <= '{normal_x, normal_y, normal_z, plane_dist};
		end
		if (accept && cmd == CMD_PIXEL) begin
			rd_s1 <= plane_mem[addr];
			coord_s1 <= coord_in;
			in_range_s1 <= in_range;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (accept && cmd == CMD_PIXEL) begin
			s1_v_q <= 1'b1;
		end else if (push) begin
			s1_v_q <= 1'b0;
		end
	end

	// entries past the table read as an all-zero plane
	assign push_item.coord = coord_s1;
	assign push_item.plane = in_range_s1 ? rd_s1 : '0;

endmodule

>>> design/pdr_fifo.sv
`timescale 1ns / 1ps
module pdr_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pdr_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output pdr_pkg::item_t head,
	output logic           empty
);
	import pdr_pkg::*;

	localparam int PW = $clog2(QDEPTH);

	item_t           slot_q [QDEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     count_q;

	assign full = (count_q == (PW + 1)'(QDEPTH));
	assign empty = (count_q == '0);
	assign head = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

>>> design/pdr_back.sv
`timescale 1ns / 1ps
module pdr_back (
	input  logic           clk,
	input  logic           arst_n,
	input  pdr_pkg::item_t head,
	input  logic           q_empty,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [8:0]     out_col,
	output logic [7:0]     out_row,
	output logic [31:0]    depth,
	output logic [7:0]     depth_byte,
	output logic           no_plane,
	output logic           saturated
);
	import pdr_pkg::*;

	localparam int LA = PH_QW + LSIN;
	localparam logic [31:0] RECIP25 = 32'((64'd1 << 32) / 64'd25);

	typedef struct packed {
		logic [8:0] out_col;
		logic [7:0] out_row;
		logic       no_plane;
		plane_t     plane;
	} tag_a_t;

	typedef struct packed {
		logic [8:0] out_col;
		logic [7:0] out_row;
		logic       no_plane;
		logic       sat;
	} tag_b_t;

	function automatic logic [15:0] fold(input logic [15:0] p);
		logic [14:0] rr;
		rr = p[14] ? 15'(15'(QUARTER) - {1'b0, p[13:0]}) : {1'b0, p[13:0]};
		return {p[15], rr};
	endfunction

	function automatic logic signed [31:0] apply_sign(input logic neg, input logic [30:0] m);
		logic signed [31:0] v;
		v = $signed({1'b0, m});
		return neg ? -v : v;
	endfunction

	logic        en;
	logic [PH_QW-1:0] qt;
	logic [PH_QW-1:0] qp;
	logic [15:0] pt;
	logic [15:0] pp;
	logic [15:0] f_sp, f_cp, f_st, f_ct;
	logic [30:0] s_sp, s_cp, s_st, s_ct;

	tag_a_t      tag_a_q [LA];
	logic        va_q [LA];
	logic [3:0]  sg_q [LSIN];

	tag_a_t      tag_v_s1;
	logic        v_v_s1;
	logic [30:0] v0_s1, v1_s1, v2_s1;
	logic        n0_s1, n1_s1, n2_s1;

	tag_b_t      tag_d1, tag_d2, tag_d3;
	logic        v_d1, v_d2, v_d3;
	logic signed [47:0] p0_d1, p1_d1, p2_d1;
	logic signed [31:0] dist_d1, dist_d2;
	logic signed [49:0] sum_d2;
	logic [32:0] dq_d3;
	logic [31:0] dmag_d3;
	logic [49:0] mag;

	logic        zero_dot;
	logic        ovf;
	tag_b_t      tag_b_q [DP_QW];
	logic        vb_q [DP_QW];
	logic [31:0] quo;

	tag_b_t      tag_o1, tag_o2;
	logic        v_o1, v_o2;
	logic [31:0] depth_o1, depth_o2;
	logic [21:0] n_o1, n_o2;
	logic [21:0] q0_o2;
	logic [21:0] rem25;
	logic [21:0] qc25;

	logic        out_valid_q;
	logic [8:0]  out_col_q;
	logic [7:0]  out_row_q;
	logic [31:0] depth_q;
	logic [7:0]  byte_q;
	logic        no_plane_q;
	logic        sat_q;

	// whole pipeline advances together; hold while the result waits
	assign en = !out_valid_q || out_ready;
	assign pop = en && !q_empty;

	pdr_div #(.DW(PH_DW), .QW(PH_QW)) u_div_t (
		.clk(clk), .en(en),
		.num_hi(PH_DW'(head.coord.pt_num[24:PH_QW])),
		.num_lo(head.coord.pt_num[PH_QW-1:0]),
		.divisor(head.coord.wm1),
		.quo(qt)
	);

	pdr_div #(.DW(PH_DW), .QW(PH_QW)) u_div_p (
		.clk(clk), .en(en),
		.num_hi(PH_DW'(head.coord.pp_num[22:PH_QW])),
		.num_lo(head.coord.pp_num[PH_QW-1:0]),
		.divisor({1'b0, head.coord.hm1}),
		.quo(qp)
	);

	assign pt = 16'(qt + PH_QW'(QUARTER));
	assign pp = qp[15:0];
	assign f_sp = fold(pp);
	assign f_cp = fold(16'(pp + 16'(QUARTER)));
	assign f_st = fold(pt);
	assign f_ct = fold(16'(pt + 16'(QUARTER)));

	pdr_sine u_sin_p (.clk(clk), .en(en), .r(f_sp[14:0]), .s(s_sp));
	pdr_sine u_cos_p (.clk(clk), .en(en), .r(f_cp[14:0]), .s(s_cp));
	pdr_sine u_sin_t (.clk(clk), .en(en), .r(f_st[14:0]), .s(s_st));
	pdr_sine u_cos_t (.clk(clk), .en(en), .r(f_ct[14:0]), .s(s_ct));

	always_ff @(posedge clk) begin
		if (en) begin
			tag_a_q[0] <= '{head.coord.out_col, head.coord.out_row, head.coord.no_plane,
				head.plane};
			for (int k = 1; k < LA; k++) tag_a_q[k] <= tag_a_q[k-1];
			sg_q[0] <= {f_sp[15], f_cp[15], f_st[15], f_ct[15]};
			for (int k = 1; k < LSIN; k++) sg_q[k] <= sg_q[k-1];
		end
	end

	// view vector
	always_ff @(posedge clk) begin
		if (en) begin
			tag_v_s1 <= tag_a_q[LA-1];
			v0_s1 <= 31'((62'(s_sp) * 62'(s_ct)) >> 30);
			v1_s1 <= 31'((62'(s_sp) * 62'(s_st)) >> 30);
			v2_s1 <= s_cp;
			n0_s1 <= sg_q[LSIN-1][3] ^ sg_q[LSIN-1][0];
			n1_s1 <= sg_q[LSIN-1][3] ^ sg_q[LSIN-1][1];
			n2_s1 <= sg_q[LSIN-1][2];
		end
	end

	assign mag = sum_d2[49] ? 50'(~sum_d2) + 50'd1 : 50'(sum_d2);

	// dot product and magnitudes
	always_ff @(posedge clk) begin
		if (en) begin
			p0_d1 <= 48'(tag_v_s1.plane.normal_x) * 48'(apply_sign(n0_s1, v0_s1));
			p1_d1 <= 48'(tag_v_s1.plane.normal_y) * 48'(apply_sign(n1_s1, v1_s1));
			p2_d1 <= 48'(tag_v_s1.plane.normal_z) * 48'(apply_sign(n2_s1, v2_s1));
			dist_d1 <= tag_v_s1.plane.plane_dist;
			tag_d1 <= '{tag_v_s1.out_col, tag_v_s1.out_row, tag_v_s1.no_plane, 1'b0};
			sum_d2 <= 50'(p0_d1) + 50'(p1_d1) + 50'(p2_d1);
			dist_d2 <= dist_d1;
			tag_d2 <= tag_d1;
			dq_d3 <= 33'(mag >> 14);
			dmag_d3 <= dist_d2[31] ? 32'(~dist_d2) + 32'd1 : 32'(dist_d2);
			tag_d3 <= tag_d2;
		end
	end

	assign zero_dot = (dq_d3 == '0);
	assign ovf = 33'(dmag_d3[31:2]) >= dq_d3;

	pdr_div #(.DW(DP_DW), .QW(DP_QW)) u_div_d (
		.clk(clk), .en(en),
		.num_hi(33'(dmag_d3[31:2])),
		.num_lo({dmag_d3[1:0], 30'd0}),
		.divisor(dq_d3),
		.quo(quo)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			tag_b_q[0] <= '{tag_d3.out_col, tag_d3.out_row, tag_d3.no_plane, zero_dot || ovf};
			for (int k = 1; k < DP_QW; k++) tag_b_q[k] <= tag_b_q[k-1];
		end
	end

	assign rem25 = n_o2 - 22'(30'(q0_o2) * 30'd25);
	assign qc25 = (rem25 >= 22'd25) ? q0_o2 + 22'd1 : q0_o2;

	// preview byte: depth * 255 / (100 << 16)
	always_ff @(posedge clk) begin
		if (en) begin
			tag_o1 <= tag_b_q[DP_QW-1];
			depth_o1 <= tag_b_q[DP_QW-1].sat ? '1 : quo;
			n_o1 <= 22'((40'(tag_b_q[DP_QW-1].sat ? '1 : quo) * 40'd255) >> 18);
			tag_o2 <= tag_o1;
			depth_o2 <= depth_o1;
			n_o2 <= n_o1;
			q0_o2 <= 22'((64'(n_o1) * 64'(RECIP25)) >> 32);
			out_col_q <= tag_o2.out_col;
			out_row_q <= tag_o2.out_row;
			no_plane_q <= tag_o2.no_plane;
			if (tag_o2.no_plane) begin
				depth_q <= '0;
				byte_q <= '0;
				sat_q <= 1'b0;
			end else begin
				depth_q <= depth_o2;
				byte_q <= (tag_o2.sat || qc25 > 22'd255) ? 8'hFF : qc25[7:0];
				sat_q <= tag_o2.sat;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LA; k++) va_q[k] <= 1'b0;
			for (int k = 0; k < DP_QW; k++) vb_q[k] <= 1'b0;
			v_v_s1 <= 1'b0;
			v_d1 <= 1'b0;
			v_d2 <= 1'b0;
			v_d3 <= 1'b0;
			v_o1 <= 1'b0;
			v_o2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			va_q[0] <= pop;
			for (int k = 1; k < LA; k++) va_q[k] <= va_q[k-1];
			v_v_s1 <= va_q[LA-1];
			v_d1 <= v_v_s1;
			v_d2 <= v_d1;
			v_d3 <= v_d2;
			vb_q[0] <= v_d3;
			for (int k = 1; k < DP_QW; k++) vb_q[k] <= vb_q[k-1];
			v_o1 <= vb_q[DP_QW-1];
			v_o2 <= v_o1;
			out_valid_q <= v_o2;
		end
	end

	assign out_valid = out_valid_q;
	assign out_col = out_col_q;
	assign out_row = out_row_q;
	assign depth = depth_q;
	assign depth_byte = byte_q;
	assign no_plane = no_plane_q;
	assign saturated = sat_q;

endmodule

>>> design/panorama_depth_plane_raycast.sv
`timescale 1ns / 1ps
// A pixel goes through the front register, queue, phase dividers, sine units,
// view, dot-product and depth-divider stages and output registers; plane loads
// give no result. Throughput: one item per cycle while the output is not
// stalled; dividers and sine units are fully pipelined, one quotient bit per
// divider stage. Reset: clears control state and sets image size to 512 x 256;
// the plane table is undefined until loaded and has no clearing pass.
module panorama_depth_plane_raycast #(
	parameter int MAX_PLANES = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                cmd,
	input  logic [8:0]          pixel_col,
	input  logic [7:0]          pixel_row,
	input  logic [7:0]          plane_index,
	input  logic signed [15:0]  normal_x,
	input  logic signed [15:0]  normal_y,
	input  logic signed [15:0]  normal_z,
	input  logic signed [31:0]  plane_dist,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [8:0]          out_col,
	output logic [7:0]          out_row,
	output logic [31:0]         depth,
	output logic [7:0]          depth_byte,
	output logic                no_plane,
	output logic                saturated,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [9:0]          cfg_data
);
	import pdr_pkg::*;

	logic  push;
	logic  pop;
	logic  q_full;
	logic  q_empty;
	item_t push_item;
	item_t head;

	pdr_front #(.MAX_PLANES(MAX_PLANES)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
		.pixel_col(pixel_col), .pixel_row(pixel_row), .plane_index(plane_index),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.plane_dist(plane_dist),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push), .push_item(push_item), .q_full(q_full)
	);

	pdr_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_item(push_item), .full(q_full),
		.pop(pop), .head(head), .empty(q_empty)
	);

	pdr_back u_back (
		.clk(clk), .arst_n(arst_n),
		.head(head), .q_empty(q_empty), .pop(pop),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_col(out_col), .out_row(out_row), .depth(depth),
		.depth_byte(depth_byte), .no_plane(no_plane), .saturated(saturated)
	);

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_full && !pop))
		else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && q_empty))
		else $error("queue underflow");

	a_no_plane: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_plane |-> depth == 32'd0 && depth_byte == 8'd0 && !saturated)
		else $error("no-plane result not zero");

	a_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> depth == 32'hFFFF_FFFF && depth_byte == 8'hFF)
		else $error("saturated result not at full scale");
`endif

endmodule
